// ===== rtl/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbse_pkg
// Types and constants shared by the LSB stego extractor modules.
// ----------------------------------------------------------------------------
package lsbse_pkg;

	localparam int BYTE_BITS = 8;
	localparam int SIZE_BITS = 32;

	typedef enum logic [3:0] {
		PH_NAME    = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_TERM    = 2'd1,
		KIND_LENGTH  = 2'd2,
		KIND_PAYLOAD = 2'd3
	} kind_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] carrier_byte;
		logic                 restart;
	} in_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data_byte;
		logic [SIZE_BITS-1:0] size_value;
		kind_t                kind;
		logic                 last;
	} out_t;

	// result handed from the gather stage to the output buffer
	typedef struct packed {
		logic valid;
		out_t item;
	} res_t;

endpackage

// ===== rtl/lsbse_gather.sv =====
// ----------------------------------------------------------------------------
// lsbse_gather
// Bit gathering state machine: collects carrier LSBs into characters, the
// length word and payload bytes, and forms one result per completed word.
// ----------------------------------------------------------------------------
module lsbse_gather #(
	parameter int LENGTH_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  lsbse_pkg::in_t    item,
	output lsbse_pkg::res_t   res
);

	// length word width held to a byte at least and a full size word at most
	localparam int LEN_W = (LENGTH_BITS < lsbse_pkg::BYTE_BITS) ? lsbse_pkg::BYTE_BITS
		: ((LENGTH_BITS > lsbse_pkg::SIZE_BITS) ? lsbse_pkg::SIZE_BITS : LENGTH_BITS);
	localparam int POS_W = $clog2(LEN_W);

	lsbse_pkg::phase_t        phase_q, phase_eff, phase_d;
	logic [POS_W-1:0]         pos_q, pos_eff, pos_d, pos_end;
	logic [LEN_W-1:0]         gather_q, gather_eff, gather_d, word;
	logic [LEN_W-1:0]         left_q, left_eff, left_d, left_dec;

	always_comb begin
		// restart puts the stream back to its start before this byte is used
		if (item.restart) begin
			phase_eff  = lsbse_pkg::PH_NAME;
			pos_eff    = '0;
			gather_eff = '0;
			left_eff   = '0;
		end else begin
			phase_eff  = phase_q;
			pos_eff    = pos_q;
			gather_eff = gather_q;
			left_eff   = left_q;
		end

		pos_end = (phase_eff == lsbse_pkg::PH_LENGTH) ? POS_W'(LEN_W - 1)
			: POS_W'(lsbse_pkg::BYTE_BITS - 1);

		word          = gather_eff;
		word[pos_eff] = item.carrier_byte[0];
		left_dec      = left_eff - LEN_W'(1);

		phase_d  = phase_eff;
		pos_d    = pos_eff;
		gather_d = gather_eff;
		left_d   = left_eff;

		res.valid           = 1'b0;
		res.item.data_byte  = '0;
		res.item.size_value = '0;
		res.item.kind       = lsbse_pkg::KIND_CHAR;
		res.item.last       = 1'b0;

		if (phase_eff != lsbse_pkg::PH_DONE) begin
			if (pos_eff != pos_end) begin
				pos_d    = pos_eff + POS_W'(1);
				gather_d = word;
			end else begin
				pos_d     = '0;
				gather_d  = '0;
				res.valid = accept;
				case (phase_eff)
					lsbse_pkg::PH_NAME: begin
						if (word[lsbse_pkg::BYTE_BITS-1:0] == '0) begin
							res.item.kind = lsbse_pkg::KIND_TERM;
							phase_d       = lsbse_pkg::PH_LENGTH;
						end else begin
							res.item.data_byte = word[lsbse_pkg::BYTE_BITS-1:0];
						end
					end
					lsbse_pkg::PH_LENGTH: begin
						res.item.kind = lsbse_pkg::KIND_LENGTH;
						if (word == '0) begin
							// empty payload: the length word closes the stream
							res.item.last = 1'b1;
							phase_d       = lsbse_pkg::PH_DONE;
						end else begin
							res.item.size_value = lsbse_pkg::SIZE_BITS'(word);
							left_d              = word;
							phase_d             = lsbse_pkg::PH_PAYLOAD;
						end
					end
					default: begin
						res.item.kind      = lsbse_pkg::KIND_PAYLOAD;
						res.item.data_byte = word[lsbse_pkg::BYTE_BITS-1:0];
						left_d             = left_dec;
						if (left_dec == '0) begin
							res.item.last = 1'b1;
							phase_d       = lsbse_pkg::PH_DONE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lsbse_pkg::PH_NAME;
			pos_q    <= '0;
			gather_q <= '0;
			left_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			gather_q <= gather_d;
			left_q   <= left_d;
		end
	end

endmodule

// ===== rtl/lsbse_out_buf.sv =====
// ----------------------------------------------------------------------------
// lsbse_out_buf
// Result register with a skid entry, so the input side keeps flowing while
// a finished result waits to be taken.
// ----------------------------------------------------------------------------
module lsbse_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  lsbse_pkg::res_t   res,
	output logic              full,
	output logic              result_valid,
	input  logic              result_stall,
	output lsbse_pkg::out_t   result
);

	logic            out_vld_q, skid_vld_q;
	lsbse_pkg::out_t out_q, skid_q;
	logic            out_free;

	assign out_free     = !out_vld_q || !result_stall;
	assign full         = skid_vld_q;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	// no new result can arrive while the skid entry is occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res.valid;
			end
		end else if (res.valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : res.item;
		end else if (res.valid) begin
			skid_q <= res.item;
		end
	end

endmodule

// ===== rtl/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// A result is registered into the output or skid entry on the carrier
// transaction that completes its word. Throughput: one carrier byte per
// cycle while the skid entry is free, set by the two-entry output buffer.
// Reset (arst_n low) returns to the name phase with all counters cleared.
// ----------------------------------------------------------------------------
module lsb_stego_extractor #(
	parameter int LENGTH_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              carrier_valid,
	output logic              carrier_stall,
	input  lsbse_pkg::in_t    carrier,
	output logic              result_valid,
	input  logic              result_stall,
	output lsbse_pkg::out_t   result
);

	logic            accept;
	logic            full;
	lsbse_pkg::res_t res;

	assign carrier_stall = full;
	assign accept        = carrier_valid && !full;

	lsbse_gather #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_gather (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (carrier),
		.res    (res)
	);

	lsbse_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
